// ----- sv/ttc_pkg.sv -----
`default_nettype none
package ttc_pkg;

   // parameter defaults
   localparam int NumCoresDefault = 4;
   localparam int TopIndexDefault = 14;

   // field widths
   localparam int CoreIdW    = 2;
   localparam int TempW      = 8;
   localparam int LimitTempW = 7;
   localparam int HystW      = 5;
   localparam int StepW      = 3;
   localparam int LowIdxW    = 4;
   localparam int MaskW      = 4;
   localparam int LimitIdxW  = 4;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 7;

   // shutdown threshold, strictly above requests power-off
   localparam logic [TempW-1:0] ShutdownTemp = 8'd85;

   // register reset values
   localparam logic [LimitTempW-1:0] LimitTempReset     = 7'd65;
   localparam logic [HystW-1:0]      LimitHystReset     = 5'd5;
   localparam logic [StepW-1:0]      StepSizeReset      = 3'd2;
   localparam logic [LowIdxW-1:0]    LowIndexReset      = 4'd4;
   localparam logic [LimitTempW-1:0] CoreLimitTempReset = 7'd75;
   localparam logic [HystW-1:0]      CoreHystReset      = 5'd10;
   localparam logic                  CoreCtlEnReset     = 1'b0;
   localparam logic [MaskW-1:0]      CoreCtlMaskReset   = 4'd14;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LIMIT_TEMP      = 3'd0,
      CSR_LIMIT_HYST      = 3'd1,
      CSR_STEP_SIZE       = 3'd2,
      CSR_LOW_INDEX       = 3'd3,
      CSR_CORE_LIMIT_TEMP = 3'd4,
      CSR_CORE_HYST       = 3'd5,
      CSR_CORE_CTL_EN     = 3'd6,
      CSR_CORE_CTL_MASK   = 3'd7
   } csr_index_type;

endpackage
`default_nettype wire

// ----- sv/thermal_throttle_controller_core.sv -----
// thermal throttle controller core
//
// input channel (req_*): one temperature sample per transfer for one core,
// with the system hotplug gate and the core's online/allowed status.
// result channel (rsp_*): one result per sample: the core's frequency-limit
// index after the sample, hardware-max and changed flags, offline/online
// requests and the power-off flag.
// configuration (csr_*): single-cycle writes of the eight control registers;
// the user must write only while the block is idle (not enforced by the
// block); writing 0 to the enable register clears all offline marks.
// samples pass through the input register, then the result register.
// throughput: one sample per cycle while rsp_stall stays low, set by the
// single compare/add/clamp pass that reads and writes the per-core state.
// back-to-back samples for the same core see each other's update.
// reset (synchronous): all indexes go to the top index, offline marks clear,
// registers take their reset values, both pipeline stages empty.
// when the receiver stalls, the result register holds; the input register
// still takes one more sample, then req_stall is raised until space frees.
`default_nettype none
module thermal_throttle_controller_core #(
   parameter int NUM_CORES = ttc_pkg::NumCoresDefault,
   parameter int TOP_INDEX = ttc_pkg::TopIndexDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ttc_pkg::CoreIdW-1:0]     req_core_id,
   input  wire logic [ttc_pkg::TempW-1:0]       req_temperature,
   input  wire logic                            req_hotplug_gate,
   input  wire logic                            req_core_online,
   input  wire logic                            req_core_allowed,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ttc_pkg::CoreIdW-1:0]          rsp_core_echo,
   output logic [ttc_pkg::LimitIdxW-1:0]        rsp_limit_index,
   output logic                                 rsp_at_hardware_max,
   output logic                                 rsp_limit_changed,
   output logic                                 rsp_request_offline,
   output logic                                 rsp_request_online,
   output logic                                 rsp_power_off,
   // configuration
   input  wire logic                            csr_wen,
   input  wire logic [ttc_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [ttc_pkg::CsrDataW-1:0]    csr_wdata
);

   // index storage wide enough for the top index
   localparam int IdxW     = (TOP_INDEX > 1) ? $clog2(TOP_INDEX + 1) : 1;
   // room for index plus step without overflow
   localparam int CmpW     = ((IdxW > ttc_pkg::LowIdxW) ? IdxW : ttc_pkg::LowIdxW) + 1;
   localparam int CoreSelW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam logic [IdxW-1:0] TopIdx = IdxW'(TOP_INDEX);

   // configuration registers
   logic [ttc_pkg::LimitTempW-1:0] limit_temp_ff;
   logic [ttc_pkg::HystW-1:0]      limit_hyst_ff;
   logic [ttc_pkg::StepW-1:0]      step_size_ff;
   logic [ttc_pkg::LowIdxW-1:0]    low_index_ff;
   logic [ttc_pkg::LimitTempW-1:0] core_limit_temp_ff;
   logic [ttc_pkg::HystW-1:0]      core_hyst_ff;
   logic                           core_ctl_en_ff;
   logic [ttc_pkg::MaskW-1:0]      core_ctl_mask_ff;

   // per-core state
   logic [IdxW-1:0] limit_idx_ff [NUM_CORES];
   logic            offline_mark_ff [NUM_CORES];

   // input register
   logic                         s1_valid_ff;
   logic [ttc_pkg::CoreIdW-1:0]  s1_core_id_ff;
   logic [ttc_pkg::TempW-1:0]    s1_temp_ff;
   logic                         s1_gate_ff;
   logic                         s1_online_ff;
   logic                         s1_allowed_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [ttc_pkg::CoreIdW-1:0]   rsp_core_echo_ff;
   logic [ttc_pkg::LimitIdxW-1:0] rsp_limit_index_ff;
   logic                          rsp_at_max_ff;
   logic                          rsp_changed_ff;
   logic                          rsp_req_off_ff;
   logic                          rsp_req_on_ff;
   logic                          rsp_power_off_ff;

   // handshake
   logic out_free;
   logic s1_fire;
   logic req_xfer;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // sample decode
   logic                core_ok;
   logic [CoreSelW-1:0] core_sel;
   logic                temp_ok;
   logic [IdxW-1:0]     old_idx;
   logic [IdxW-1:0]     limit_idx_in;
   logic                mark_set;
   logic                mark_clr;
   logic                req_off;
   logic                req_on;

   assign core_ok  = 32'(s1_core_id_ff) < 32'(NUM_CORES);
   assign core_sel = CoreSelW'(s1_core_id_ff);
   assign temp_ok  = s1_temp_ff != '0;
   assign old_idx  = limit_idx_ff[core_sel];

   // frequency thresholds, cool-down threshold is signed so a small limit never steps up
   logic               freq_hot;
   logic               freq_cool;
   logic signed [9:0]  freq_cool_thr;
   logic signed [9:0]  temp_s;

   assign temp_s        = $signed({2'b00, s1_temp_ff});
   assign freq_cool_thr = $signed({3'b000, limit_temp_ff}) - $signed({5'b00000, limit_hyst_ff});
   assign freq_hot      = {1'b0, s1_temp_ff} >= {2'b00, limit_temp_ff};
   assign freq_cool     = temp_s < freq_cool_thr;

   // index step with saturation at both bounds
   logic [CmpW-1:0] lo_w;
   logic [CmpW-1:0] old_w;
   logic [CmpW-1:0] step_w;

   assign lo_w   = (CmpW'(low_index_ff) > CmpW'(TOP_INDEX)) ? CmpW'(TOP_INDEX)
                                                            : CmpW'(low_index_ff);
   assign old_w  = CmpW'(old_idx);
   assign step_w = CmpW'(step_size_ff);

   always_comb begin
      limit_idx_in = old_idx;
      if (temp_ok) begin
         if (freq_hot) begin
            if (old_w >= lo_w + step_w) begin
               limit_idx_in = IdxW'(old_w - step_w);
            end else begin
               limit_idx_in = IdxW'(lo_w);
            end
         end else if (freq_cool) begin
            if (old_w + step_w <= CmpW'(TOP_INDEX)) begin
               limit_idx_in = IdxW'(old_w + step_w);
            end else begin
               limit_idx_in = TopIdx;
            end
         end
      end
   end

   // core offline control
   logic              core_ctl_on;
   logic              mask_bit;
   logic              core_hot;
   logic              core_cool;
   logic signed [9:0] core_cool_thr;

   assign core_ctl_on   = core_ctl_en_ff && s1_gate_ff && (core_ctl_mask_ff != '0);
   assign mask_bit      = core_ctl_mask_ff[s1_core_id_ff];
   assign core_cool_thr = $signed({3'b000, core_limit_temp_ff})
                        - $signed({5'b00000, core_hyst_ff});
   assign core_hot      = {1'b0, s1_temp_ff} >= {2'b00, core_limit_temp_ff};
   assign core_cool     = temp_s < core_cool_thr;

   always_comb begin
      mark_set = 1'b0;
      mark_clr = 1'b0;
      req_off  = 1'b0;
      req_on   = 1'b0;
      if (core_ok && temp_ok && core_ctl_on) begin
         if (core_hot && mask_bit) begin
            mark_set = 1'b1;
            req_off  = s1_online_ff;
         end else if (core_cool && mask_bit && offline_mark_ff[core_sel]) begin
            mark_clr = 1'b1;
            req_on   = !s1_online_ff && s1_allowed_ff;
         end
      end
   end

   // configuration writes
   logic clear_marks;

   assign clear_marks = csr_wen
                     && (ttc_pkg::csr_index_type'(csr_index) == ttc_pkg::CSR_CORE_CTL_EN)
                     && !csr_wdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_temp_ff      <= ttc_pkg::LimitTempReset;
         limit_hyst_ff      <= ttc_pkg::LimitHystReset;
         step_size_ff       <= ttc_pkg::StepSizeReset;
         low_index_ff       <= ttc_pkg::LowIndexReset;
         core_limit_temp_ff <= ttc_pkg::CoreLimitTempReset;
         core_hyst_ff       <= ttc_pkg::CoreHystReset;
         core_ctl_en_ff     <= ttc_pkg::CoreCtlEnReset;
         core_ctl_mask_ff   <= ttc_pkg::CoreCtlMaskReset;
      end else if (csr_wen) begin
         case (ttc_pkg::csr_index_type'(csr_index))
            ttc_pkg::CSR_LIMIT_TEMP:      limit_temp_ff      <= csr_wdata;
            ttc_pkg::CSR_LIMIT_HYST:      limit_hyst_ff      <= csr_wdata[ttc_pkg::HystW-1:0];
            ttc_pkg::CSR_STEP_SIZE:       step_size_ff       <= csr_wdata[ttc_pkg::StepW-1:0];
            ttc_pkg::CSR_LOW_INDEX:       low_index_ff       <= csr_wdata[ttc_pkg::LowIdxW-1:0];
            ttc_pkg::CSR_CORE_LIMIT_TEMP: core_limit_temp_ff <= csr_wdata;
            ttc_pkg::CSR_CORE_HYST:       core_hyst_ff       <= csr_wdata[ttc_pkg::HystW-1:0];
            ttc_pkg::CSR_CORE_CTL_EN:     core_ctl_en_ff     <= csr_wdata[0];
            ttc_pkg::CSR_CORE_CTL_MASK:   core_ctl_mask_ff   <= csr_wdata[ttc_pkg::MaskW-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-core state update, written when the sample moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CORES; c++) begin
            limit_idx_ff[c]    <= TopIdx;
            offline_mark_ff[c] <= 1'b0;
         end
      end else begin
         if (s1_fire && core_ok && temp_ok) begin
            limit_idx_ff[core_sel] <= limit_idx_in;
            if (mark_set) begin
               offline_mark_ff[core_sel] <= 1'b1;
            end else if (mark_clr) begin
               offline_mark_ff[core_sel] <= 1'b0;
            end
         end
         if (clear_marks) begin
            for (int c = 0; c < NUM_CORES; c++) begin
               offline_mark_ff[c] <= 1'b0;
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_core_id_ff <= req_core_id;
         s1_temp_ff    <= req_temperature;
         s1_gate_ff    <= req_hotplug_gate;
         s1_online_ff  <= req_core_online;
         s1_allowed_ff <= req_core_allowed;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_core_echo_ff   <= s1_core_id_ff;
         rsp_power_off_ff   <= s1_temp_ff > ttc_pkg::ShutdownTemp;
         rsp_req_off_ff     <= req_off;
         rsp_req_on_ff      <= req_on;
         // a core beyond the table reports a zero index, no hardware-max and no change
         rsp_limit_index_ff <= core_ok ? ttc_pkg::LimitIdxW'(limit_idx_in) : '0;
         rsp_at_max_ff      <= core_ok && (limit_idx_in == TopIdx);
         rsp_changed_ff     <= core_ok && (limit_idx_in != old_idx);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_core_echo       = rsp_core_echo_ff;
   assign rsp_limit_index     = rsp_limit_index_ff;
   assign rsp_at_hardware_max = rsp_at_max_ff;
   assign rsp_limit_changed   = rsp_changed_ff;
   assign rsp_request_offline = rsp_req_off_ff;
   assign rsp_request_online  = rsp_req_on_ff;
   assign rsp_power_off       = rsp_power_off_ff;

endmodule
`default_nettype wire

// ----- sv/ttc_checker.sv -----
`default_nettype none
module ttc_checker #(
   parameter int TOP_INDEX = ttc_pkg::TopIndexDefault
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [ttc_pkg::CoreIdW-1:0]   rsp_core_echo,
   input wire logic [ttc_pkg::LimitIdxW-1:0] rsp_limit_index,
   input wire logic                          rsp_at_hardware_max,
   input wire logic                          rsp_limit_changed,
   input wire logic                          rsp_request_offline,
   input wire logic                          rsp_request_online,
   input wire logic                          rsp_power_off
);

   // result register empty and no input stall right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // a core never gets both requests from one sample
   a_req_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_request_offline && rsp_request_online))
      else $error("offline and online requested together");

   // hardware-max flag only with the top index
   a_top_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_hardware_max)
         |-> (rsp_limit_index == ttc_pkg::LimitIdxW'(TOP_INDEX)))
      else $error("hardware max flagged away from top index");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_core_echo)
         && $stable(rsp_limit_index) && $stable(rsp_at_hardware_max)
         && $stable(rsp_limit_changed) && $stable(rsp_request_offline)
         && $stable(rsp_request_online) && $stable(rsp_power_off)))
      else $error("stalled result changed");

endmodule

bind thermal_throttle_controller_core ttc_checker #(.TOP_INDEX(TOP_INDEX)) u_ttc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_core_echo       (rsp_core_echo),
   .rsp_limit_index     (rsp_limit_index),
   .rsp_at_hardware_max (rsp_at_hardware_max),
   .rsp_limit_changed   (rsp_limit_changed),
   .rsp_request_offline (rsp_request_offline),
   .rsp_request_online  (rsp_request_online),
   .rsp_power_off       (rsp_power_off)
);
`default_nettype wire

// ----- tb/tb_thermal_throttle_controller_core.sv -----
`default_nettype none
module tb_thermal_throttle_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumCores      = ttc_pkg::NumCoresDefault;
   localparam int TopIdx        = ttc_pkg::TopIndexDefault;
   // cycles with no transfer and no register write before the run is declared hung
   localparam int IdleLimit     = 5000;
   localparam int PhaseCount    = 10;
   localparam int ItemsPerPhase = 200;

   // one result as seen on the rsp_ channel, msb first in port order
   typedef struct packed {
      logic [ttc_pkg::CoreIdW-1:0]   core_echo;
      logic [ttc_pkg::LimitIdxW-1:0] limit_index;
      logic                          at_hardware_max;
      logic                          limit_changed;
      logic                          request_offline;
      logic                          request_online;
      logic                          power_off;
   } throttle_result_type;

   // register values of one test phase
   typedef struct {
      int limit_temp;
      int limit_hyst;
      int step_size;
      int low_index;
      int core_limit_temp;
      int core_hyst;
      int core_ctl_en;
      int core_ctl_mask;
   } throttle_setting_type;

   // per-core throttle predictor plus the queue of results it still owes
   class throttle_scoreboard;
      logic [ttc_pkg::LimitTempW-1:0] limit_temp;
      logic [ttc_pkg::HystW-1:0]      limit_hyst;
      logic [ttc_pkg::StepW-1:0]      step_size;
      logic [ttc_pkg::LowIdxW-1:0]    low_index;
      logic [ttc_pkg::LimitTempW-1:0] core_limit_temp;
      logic [ttc_pkg::HystW-1:0]      core_hyst;
      logic                           core_ctl_en;
      logic [ttc_pkg::MaskW-1:0]      core_ctl_mask;
      int                             core_index [NumCores];
      bit                             offline_mark [NumCores];
      throttle_result_type            owed_results [$];
      int                             errors;

      function new();
         limit_temp      = ttc_pkg::LimitTempReset;
         limit_hyst      = ttc_pkg::LimitHystReset;
         step_size       = ttc_pkg::StepSizeReset;
         low_index       = ttc_pkg::LowIndexReset;
         core_limit_temp = ttc_pkg::CoreLimitTempReset;
         core_hyst       = ttc_pkg::CoreHystReset;
         core_ctl_en     = ttc_pkg::CoreCtlEnReset;
         core_ctl_mask   = ttc_pkg::CoreCtlMaskReset;
         foreach (core_index[c]) begin
            core_index[c]   = TopIdx;
            offline_mark[c] = 1'b0;
         end
         errors = 0;
      endfunction

      function void write_reg(ttc_pkg::csr_index_type idx,
                              logic [ttc_pkg::CsrDataW-1:0] data);
         case (idx)
            ttc_pkg::CSR_LIMIT_TEMP:      limit_temp      = data[ttc_pkg::LimitTempW-1:0];
            ttc_pkg::CSR_LIMIT_HYST:      limit_hyst      = data[ttc_pkg::HystW-1:0];
            ttc_pkg::CSR_STEP_SIZE:       step_size       = data[ttc_pkg::StepW-1:0];
            ttc_pkg::CSR_LOW_INDEX:       low_index       = data[ttc_pkg::LowIdxW-1:0];
            ttc_pkg::CSR_CORE_LIMIT_TEMP: core_limit_temp = data[ttc_pkg::LimitTempW-1:0];
            ttc_pkg::CSR_CORE_HYST:       core_hyst       = data[ttc_pkg::HystW-1:0];
            ttc_pkg::CSR_CORE_CTL_EN: begin
               core_ctl_en = data[0];
               // disabling core control forgets every offline mark
               if (!data[0]) begin
                  foreach (offline_mark[c]) offline_mark[c] = 1'b0;
               end
            end
            ttc_pkg::CSR_CORE_CTL_MASK:   core_ctl_mask   = data[ttc_pkg::MaskW-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [ttc_pkg::CoreIdW-1:0] core,
                                logic [ttc_pkg::TempW-1:0] temp,
                                logic gate, logic online, logic allowed);
         int                  old_idx;
         int                  new_idx;
         int                  floor_idx;
         int                  t;
         throttle_result_type r;
         r           = '0;
         t           = int'(temp);
         r.core_echo = core;
         r.power_off = (temp > ttc_pkg::ShutdownTemp);
         old_idx     = core_index[core];
         new_idx     = old_idx;
         floor_idx   = (int'(low_index) > TopIdx) ? TopIdx : int'(low_index);
         if (t != 0) begin
            if (t >= int'(limit_temp)) begin
               if (new_idx >= floor_idx + int'(step_size)) new_idx -= int'(step_size);
               else new_idx = floor_idx;
            end else if (t < int'(limit_temp) - int'(limit_hyst)) begin
               if (new_idx + int'(step_size) <= TopIdx) new_idx += int'(step_size);
               else new_idx = TopIdx;
            end
            core_index[core] = new_idx;
            if (core_ctl_en && gate && core_ctl_mask != '0) begin
               if (t >= int'(core_limit_temp) && core_ctl_mask[core]) begin
                  offline_mark[core] = 1'b1;
                  r.request_offline  = online;
               end else if (t < int'(core_limit_temp) - int'(core_hyst) &&
                            core_ctl_mask[core] && offline_mark[core]) begin
                  offline_mark[core] = 1'b0;
                  r.request_online   = !online && allowed;
               end
            end
         end
         r.limit_index     = new_idx[ttc_pkg::LimitIdxW-1:0];
         r.at_hardware_max = (new_idx == TopIdx);
         r.limit_changed   = (new_idx != old_idx);
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            errors++;
         end
      endfunction

      function void check_result(throttle_result_type got);
         throttle_result_type exp_r;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         exp_r = owed_results.pop_front();
         compare_field("core_echo", exp_r.core_echo, got.core_echo);
         compare_field("limit_index", exp_r.limit_index, got.limit_index);
         compare_field("at_hardware_max", exp_r.at_hardware_max, got.at_hardware_max);
         compare_field("limit_changed", exp_r.limit_changed, got.limit_changed);
         compare_field("request_offline", exp_r.request_offline, got.request_offline);
         compare_field("request_online", exp_r.request_online, got.request_online);
         compare_field("power_off", exp_r.power_off, got.power_off);
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [ttc_pkg::CoreIdW-1:0]    req_core_id;
   logic [ttc_pkg::TempW-1:0]      req_temperature;
   logic                           req_hotplug_gate;
   logic                           req_core_online;
   logic                           req_core_allowed;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [ttc_pkg::CoreIdW-1:0]    rsp_core_echo;
   logic [ttc_pkg::LimitIdxW-1:0]  rsp_limit_index;
   logic                           rsp_at_hardware_max;
   logic                           rsp_limit_changed;
   logic                           rsp_request_offline;
   logic                           rsp_request_online;
   logic                           rsp_power_off;
   logic                           csr_wen;
   logic [ttc_pkg::CsrIdxW-1:0]    csr_index;
   logic [ttc_pkg::CsrDataW-1:0]   csr_wdata;

   throttle_scoreboard    sb;
   throttle_result_type   observed;
   throttle_setting_type  cur;
   // random idling on/off, shared by sender and receiver
   bit                    idling_on;
   int                    quiet_cycles;

   thermal_throttle_controller_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_core_id         (req_core_id),
      .req_temperature     (req_temperature),
      .req_hotplug_gate    (req_hotplug_gate),
      .req_core_online     (req_core_online),
      .req_core_allowed    (req_core_allowed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_core_echo       (rsp_core_echo),
      .rsp_limit_index     (rsp_limit_index),
      .rsp_at_hardware_max (rsp_at_hardware_max),
      .rsp_limit_changed   (rsp_limit_changed),
      .rsp_request_offline (rsp_request_offline),
      .rsp_request_online  (rsp_request_online),
      .rsp_power_off       (rsp_power_off),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result payload packed in struct field order
   assign observed = {rsp_core_echo, rsp_limit_index, rsp_at_hardware_max,
                      rsp_limit_changed, rsp_request_offline, rsp_request_online,
                      rsp_power_off};

   // monitor: everything sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         // check first, a sample accepted now cannot have its result yet
         if (rsp_valid && !rsp_stall) sb.check_result(observed);
         if (req_valid && !req_stall) begin
            sb.note_sample(req_core_id, req_temperature, req_hotplug_gate,
                           req_core_online, req_core_allowed);
         end
         if (csr_wen) sb.write_reg(ttc_pkg::csr_index_type'(csr_index), csr_wdata);
      end
   end

   // watchdog: too long without any transfer or register write means hung
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("tb_thermal_throttle_controller_core NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random back-pressure, changed only at the falling edge
   always @(negedge clock) begin
      rsp_stall <= idling_on ? ($urandom_range(99) < 14) : 1'b0;
   end

   // one sample transfer; valid stays high afterwards until the next call decides
   task automatic send_sample(int core, int temp, int gate, int online, int allowed);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_core_id      <= core[ttc_pkg::CoreIdW-1:0];
      req_temperature  <= temp[ttc_pkg::TempW-1:0];
      req_hotplug_gate <= gate[0];
      req_core_online  <= online[0];
      req_core_allowed <= allowed[0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every owed result has come back
   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.owed_results.size() != 0) @(negedge clock);
   endtask

   // single register write, only with the block drained
   task automatic write_csr(ttc_pkg::csr_index_type idx, int value);
      wait_results_done();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[ttc_pkg::CsrDataW-1:0];
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic program_setting(throttle_setting_type s);
      cur = s;
      write_csr(ttc_pkg::CSR_LIMIT_TEMP, s.limit_temp);
      write_csr(ttc_pkg::CSR_LIMIT_HYST, s.limit_hyst);
      write_csr(ttc_pkg::CSR_STEP_SIZE, s.step_size);
      write_csr(ttc_pkg::CSR_LOW_INDEX, s.low_index);
      write_csr(ttc_pkg::CSR_CORE_LIMIT_TEMP, s.core_limit_temp);
      write_csr(ttc_pkg::CSR_CORE_HYST, s.core_hyst);
      write_csr(ttc_pkg::CSR_CORE_CTL_MASK, s.core_ctl_mask);
      write_csr(ttc_pkg::CSR_CORE_CTL_EN, s.core_ctl_en);
   endtask

   // mostly legal ranges, now and then anything the register width holds
   function automatic throttle_setting_type random_setting();
      throttle_setting_type s;
      bit                   wild;
      wild              = ($urandom_range(7) == 0);
      s.limit_temp      = wild ? $urandom_range(127) : $urandom_range(81, 35);
      s.limit_hyst      = wild ? $urandom_range(31) : $urandom_range(20, 1);
      s.step_size       = wild ? $urandom_range(7) : $urandom_range(5, 1);
      s.low_index       = wild ? $urandom_range(15) : $urandom_range(14);
      s.core_limit_temp = wild ? $urandom_range(127) : $urandom_range(80, 34);
      s.core_hyst       = wild ? $urandom_range(31) : $urandom_range(20, 1);
      s.core_ctl_en     = ($urandom_range(4) != 0);
      s.core_ctl_mask   = $urandom_range(15);
      return s;
   endfunction

   // temperatures clustered around the active thresholds
   function automatic logic [ttc_pkg::TempW-1:0] pick_temp();
      int r;
      int t;
      r = $urandom_range(99);
      if (r < 5) t = 0;
      else if (r < 15) t = $urandom_range(255);
      else if (r < 55) t = cur.limit_temp - cur.limit_hyst - 3 +
                           $urandom_range(cur.limit_hyst + 6);
      else if (r < 92) t = cur.core_limit_temp - cur.core_hyst - 3 +
                           $urandom_range(cur.core_hyst + 6);
      else t = $urandom_range(90, 80);
      if (r >= 15) begin
         if (t < 1) t = 1;
         if (t > 255) t = 255;
      end
      return t[ttc_pkg::TempW-1:0];
   endfunction

   initial begin
      throttle_setting_type s;
      sb               = new();
      idling_on        = 1'b1;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_core_id      = '0;
      req_temperature  = '0;
      req_hotplug_gate = 1'b0;
      req_core_online  = 1'b0;
      req_core_allowed = 1'b0;
      rsp_stall        = 1'b0;
      csr_wen          = 1'b0;
      csr_index        = ttc_pkg::CSR_LIMIT_TEMP;
      csr_wdata        = '0;
      cur              = '{ttc_pkg::LimitTempReset, ttc_pkg::LimitHystReset,
                           ttc_pkg::StepSizeReset, ttc_pkg::LowIndexReset,
                           ttc_pkg::CoreLimitTempReset, ttc_pkg::CoreHystReset,
                           ttc_pkg::CoreCtlEnReset, ttc_pkg::CoreCtlMaskReset};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: invalid reading, shutdown edge, step down to the floor
      send_sample(0, 0, 1, 1, 1);
      send_sample(0, 255, 1, 1, 1);
      send_sample(0, 86, 1, 1, 1);
      send_sample(0, 85, 1, 1, 1);
      send_sample(0, 65, 1, 1, 1);
      send_sample(0, 65, 1, 1, 1);
      send_sample(0, 65, 1, 1, 1);
      // inside the hysteresis band, then just below it
      send_sample(0, 62, 1, 1, 1);
      send_sample(0, 60, 1, 1, 1);
      send_sample(0, 59, 1, 1, 1);
      // already at the top, saturates
      send_sample(1, 1, 1, 1, 1);

      // core offline control on every core
      write_csr(ttc_pkg::CSR_CORE_CTL_MASK, 15);
      write_csr(ttc_pkg::CSR_CORE_CTL_EN, 1);
      send_sample(2, 75, 1, 1, 0);
      send_sample(2, 80, 0, 1, 1);
      send_sample(2, 64, 1, 0, 1);
      send_sample(3, 76, 1, 0, 1);
      send_sample(3, 50, 1, 0, 0);
      send_sample(1, 76, 1, 1, 1);
      // disable clears the mark, so no online request after re-enable
      write_csr(ttc_pkg::CSR_CORE_CTL_EN, 0);
      write_csr(ttc_pkg::CSR_CORE_CTL_EN, 1);
      send_sample(1, 40, 1, 0, 1);

      // zero step, floor above top, threshold below hysteresis, empty mask
      write_csr(ttc_pkg::CSR_STEP_SIZE, 0);
      write_csr(ttc_pkg::CSR_LOW_INDEX, 15);
      write_csr(ttc_pkg::CSR_LIMIT_TEMP, 10);
      write_csr(ttc_pkg::CSR_LIMIT_HYST, 20);
      write_csr(ttc_pkg::CSR_CORE_CTL_MASK, 0);
      send_sample(0, 200, 1, 1, 1);
      send_sample(0, 5, 1, 1, 1);
      send_sample(2, 80, 1, 1, 1);

      // big step close to both bounds
      write_csr(ttc_pkg::CSR_STEP_SIZE, 7);
      write_csr(ttc_pkg::CSR_LOW_INDEX, 3);
      write_csr(ttc_pkg::CSR_LIMIT_TEMP, 35);
      write_csr(ttc_pkg::CSR_LIMIT_HYST, 1);
      write_csr(ttc_pkg::CSR_CORE_CTL_MASK, 15);
      send_sample(0, 100, 1, 1, 1);
      send_sample(0, 100, 1, 1, 1);
      send_sample(0, 1, 1, 1, 1);
      send_sample(0, 1, 1, 1, 1);

      // random phases, each with its own register setting
      for (int ph = 0; ph < PhaseCount; ph++) begin
         case (ph)
            0: s = '{35, 1, 1, 0, 34, 1, 1, 15};
            1: s = '{81, 20, 5, 14, 80, 20, 1, 15};
            2: s = '{127, 31, 7, 15, 127, 31, 1, 15};
            3: s = '{0, 0, 0, 0, 0, 0, 1, 0};
            default: s = random_setting();
         endcase
         program_setting(s);
         // one phase runs flat out on both sides
         idling_on = (ph != 5);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            // mid-phase drain with the sender held off
            if (ph == 7 && n == ItemsPerPhase / 2) wait_results_done();
            send_sample($urandom_range(3), pick_temp(), ($urandom_range(9) != 0),
                        $urandom_range(1), $urandom_range(1));
         end
      end
      idling_on = 1'b1;

      // drain, then watch on for stray results before the verdict
      wait_results_done();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_thermal_throttle_controller_core OK");
      end else begin
         $display("tb_thermal_throttle_controller_core NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
